// ----- hdl/vurp_pkg.sv -----
// ----------------------------------------------------------------------------
// vurp_pkg: shared types and constants
// Commands, register indexes and controller-to-datapath signal groups.
// ----------------------------------------------------------------------------
package vurp_pkg;

    // Command codes of an input beat.
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // Register indexes.
    localparam logic [2:0] REG_CONTROL = 3'd0;
    localparam logic [2:0] REG_MASK    = 3'd1;
    localparam logic [2:0] REG_STATUS  = 3'd2;
    localparam logic [2:0] REG_SCROLL  = 3'd5;
    localparam logic [2:0] REG_ADDRESS = 3'd6;
    localparam logic [2:0] REG_DATA    = 3'd7;

    // Memory sizes.
    localparam int PATTERN_BYTES = 8192;
    localparam int PAT_AW        = $clog2(PATTERN_BYTES);
    localparam int NT_AW         = 11;
    localparam int PAL_AW        = 5;

    // Timing counter limits.
    localparam logic [8:0] DOT_LAST   = 9'd340;
    localparam logic [8:0] LINE_VBL   = 9'd241;
    localparam logic [8:0] LINE_LAST  = 9'd260;
    localparam logic [8:0] LINE_PRE   = 9'h1FF;

    // Controller commands to the datapath.
    typedef struct packed {
        logic       exec;     // perform the beat's register effects
        logic       finish;   // finish state of a data read: take memory data
        logic [1:0] cmd;
        logic [2:0] sel;
        logic [7:0] data;
    } vurp_cmd_t;

endpackage

// ----- hdl/vurp_ctrl.sv -----
// ----------------------------------------------------------------------------
// vurp_ctrl: beat controller
// Captures a beat, issues it to the datapath, and adds a finish state for a
// data-port read that needs a memory read.
// ----------------------------------------------------------------------------
module vurp_ctrl
    import vurp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] command,
    input  logic [2:0] reg_select,
    input  logic [7:0] write_data,
    output logic       busy,
    output vurp_cmd_t  dp_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [1:0] cmd_reg;
    logic [2:0] sel_reg;
    logic [7:0] data_reg;
    logic       accept;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (cmd_reg == CMD_READ && sel_reg == REG_DATA)
                    state_next = ST_FIN;
                else
                    state_next = ST_IDLE;
            end
            ST_FIN:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Beat capture.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= command;
            sel_reg  <= reg_select;
            data_reg <= write_data;
        end
    end

    assign dp_cmd.exec   = (state_reg == ST_EXEC);
    assign dp_cmd.finish = (state_reg == ST_FIN);
    assign dp_cmd.cmd    = cmd_reg;
    assign dp_cmd.sel    = sel_reg;
    assign dp_cmd.data   = data_reg;

endmodule

// ----- hdl/vurp_datapath.sv -----
// ----------------------------------------------------------------------------
// vurp_datapath: registers, memories and timing counters
// Executes issued beats and drives the result strobe.
// ----------------------------------------------------------------------------
module vurp_datapath
    import vurp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  vurp_cmd_t  dp_cmd,
    input  logic       mirror_vertical,
    output logic       done,
    output logic [7:0] read_data,
    output logic       nmi
);

    logic [7:0]  control_reg, mask_reg, read_buffer_reg;
    logic        vblank_reg, toggle_reg;
    logic [2:0]  fine_x_reg;
    logic [14:0] temp_reg, vaddr_reg;
    logic [8:0]  line_reg, dot_reg;
    logic        done_reg, nmi_reg;
    logic [7:0]  rdata_reg;

    logic [7:0] pat_mem [PATTERN_BYTES];
    logic [7:0] nt_mem  [2**NT_AW];
    logic [5:0] pal_mem [2**PAL_AW];
    logic [7:0] pat_rd_reg, nt_rd_reg;
    logic [5:0] pal_rd_reg;
    logic [1:0] region_reg;

    // Address decode.
    logic [13:0]       bus_a;
    logic              is_pat, is_pal;
    logic [PAT_AW-1:0] pat_idx;
    logic [NT_AW-1:0]  nt_idx;
    logic [PAL_AW-1:0] pal_idx;
    logic [14:0]       vaddr_inc;

    assign bus_a   = vaddr_reg[13:0];
    assign is_pat  = (bus_a < 14'h2000);
    assign is_pal  = (bus_a >= 14'h3F00);
    assign pat_idx = bus_a[PAT_AW-1:0];
    assign nt_idx  = {mirror_vertical ? bus_a[10] : bus_a[11], bus_a[9:0]};
    assign pal_idx = ((bus_a[4:0] & 5'h13) == 5'h10) ? {1'b0, bus_a[3:0]} : bus_a[4:0];
    assign vaddr_inc = vaddr_reg + (control_reg[2] ? 15'd32 : 15'd1);

    logic wr_data, rd_data;
    assign wr_data = dp_cmd.exec && dp_cmd.cmd == CMD_WRITE && dp_cmd.sel == REG_DATA;
    assign rd_data = dp_cmd.exec && dp_cmd.cmd == CMD_READ && dp_cmd.sel == REG_DATA;

    // Memories: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_data && is_pat)
            pat_mem[pat_idx] <= dp_cmd.data;
        if (wr_data && !is_pat && !is_pal)
            nt_mem[nt_idx] <= dp_cmd.data;
        if (wr_data && is_pal)
            pal_mem[pal_idx] <= dp_cmd.data[5:0];
        pat_rd_reg <= pat_mem[pat_idx];
        nt_rd_reg  <= nt_mem[nt_idx];
        pal_rd_reg <= pal_mem[pal_idx];
        if (rd_data)
            region_reg <= is_pat ? 2'd0 : (is_pal ? 2'd2 : 2'd1);
    end

    // Memory read data, palette masked by grayscale.
    logic [7:0] mem_q;
    always_comb
    begin
        unique case (region_reg)
            2'd0:    mem_q = pat_rd_reg;
            2'd1:    mem_q = nt_rd_reg;
            default: mem_q = {2'b00, pal_rd_reg & (mask_reg[0] ? 6'h30 : 6'h3F)};
        endcase
    end

    // Register file and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_reg     <= '0;
            mask_reg        <= '0;
            read_buffer_reg <= '0;
            vblank_reg      <= 1'b0;
            toggle_reg      <= 1'b0;
            fine_x_reg      <= '0;
            temp_reg        <= '0;
            vaddr_reg       <= '0;
            line_reg        <= '0;
            dot_reg         <= '0;
            done_reg        <= 1'b0;
            nmi_reg         <= 1'b0;
            rdata_reg       <= '0;
        end
        else
        begin
            done_reg  <= 1'b0;
            nmi_reg   <= 1'b0;
            rdata_reg <= '0;
            if (dp_cmd.finish)
            begin
                // Finish state of a data read: result from old buffer or palette.
                done_reg        <= 1'b1;
                rdata_reg       <= (region_reg == 2'd2) ? mem_q : read_buffer_reg;
                read_buffer_reg <= mem_q;
            end
            else if (dp_cmd.exec)
            begin
                done_reg <= !rd_data;
                unique case (dp_cmd.cmd)
                    CMD_WRITE:
                    begin
                        unique case (dp_cmd.sel)
                            REG_CONTROL:
                            begin
                                control_reg    <= dp_cmd.data;
                                temp_reg[11:10] <= dp_cmd.data[1:0];
                            end
                            REG_MASK:
                                mask_reg <= dp_cmd.data;
                            REG_SCROLL:
                            begin
                                if (!toggle_reg)
                                begin
                                    fine_x_reg    <= dp_cmd.data[2:0];
                                    temp_reg[4:0] <= dp_cmd.data[7:3];
                                end
                                else
                                begin
                                    temp_reg[14:12] <= dp_cmd.data[2:0];
                                    temp_reg[9:5]   <= dp_cmd.data[7:3];
                                end
                                toggle_reg <= !toggle_reg;
                            end
                            REG_ADDRESS:
                            begin
                                if (!toggle_reg)
                                    temp_reg[14:8] <= {1'b0, dp_cmd.data[5:0]};
                                else
                                begin
                                    temp_reg[7:0] <= dp_cmd.data;
                                    vaddr_reg     <= {temp_reg[14:8], dp_cmd.data};
                                end
                                toggle_reg <= !toggle_reg;
                            end
                            REG_DATA:
                                vaddr_reg <= vaddr_inc;
                            default:
                            begin
                            end
                        endcase
                    end
                    CMD_READ:
                    begin
                        if (dp_cmd.sel == REG_STATUS)
                        begin
                            rdata_reg  <= {vblank_reg, 2'b00, read_buffer_reg[4:0]};
                            vblank_reg <= 1'b0;
                            toggle_reg <= 1'b0;
                        end
                        else if (dp_cmd.sel == REG_DATA)
                            vaddr_reg <= vaddr_inc;
                    end
                    CMD_TICK:
                    begin
                        if (line_reg == LINE_VBL && dot_reg == 9'd1)
                        begin
                            vblank_reg <= 1'b1;
                            nmi_reg    <= control_reg[7];
                        end
                        if (line_reg == LINE_PRE && dot_reg == 9'd1)
                            vblank_reg <= 1'b0;
                        if (dot_reg >= DOT_LAST)
                        begin
                            dot_reg  <= '0;
                            line_reg <= (line_reg == LINE_LAST) ? LINE_PRE : line_reg + 9'd1;
                        end
                        else
                            dot_reg <= dot_reg + 9'd1;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assign done      = done_reg;
    assign read_data = rdata_reg;
    assign nmi       = nmi_reg;

endmodule

// ----- hdl/video_unit_register_port.sv -----
// ----------------------------------------------------------------------------
// video_unit_register_port: CPU register port of a tile video unit
// Register access, buffered data port with video memories, dot timing.
// ----------------------------------------------------------------------------
// A beat is taken when start is high and busy is low. Its result appears on
// read_data and nmi for one cycle with done high, once the captured beat has
// been executed in the EXEC state and registered; a data-port read also passes
// the FIN state, which waits on one synchronous memory read. The receiver
// cannot stall. mirror_vertical is written through the APB port at address 0.
module video_unit_register_port
    import vurp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  command,
    input  logic [2:0]  reg_select,
    input  logic [7:0]  write_data,
    output logic        done,
    output logic [7:0]  read_data,
    output logic        nmi,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic      mirror_reg;
    vurp_cmd_t dp_cmd;

    // Configuration register.
    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mirror_reg <= 1'b0;
        else if (psel && penable && pwrite && paddr == 2'd0)
            mirror_reg <= pwdata[0];
    end
    assign prdata = (paddr == 2'd0) ? {31'd0, mirror_reg} : 32'd0;

    vurp_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .command    (command),
        .reg_select (reg_select),
        .write_data (write_data),
        .busy       (busy),
        .dp_cmd     (dp_cmd)
    );

    vurp_datapath u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .dp_cmd          (dp_cmd),
        .mirror_vertical (mirror_reg),
        .done            (done),
        .read_data       (read_data),
        .nmi             (nmi)
    );

endmodule
